// ===== sv/jcc_pkg.sv =====
package jcc_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_ZWNJ      = 21'h0200C;
  localparam logic [CP_W-1:0] CP_ZWJ       = 21'h0200D;
  localparam logic [CP_W-1:0] CP_FATHATAN  = 21'h0064B;
  localparam logic [CP_W-1:0] CP_ALM       = 21'h0061C;
  localparam logic [CP_W-1:0] CP_BEH       = 21'h00628;
  localparam logic [CP_W-1:0] CP_LAM       = 21'h00644;
  localparam logic [CP_W-1:0] CP_ALEF      = 21'h00627;

  localparam int unsigned VIRAMA_COUNT = 21;

  localparam logic [CP_W-1:0] VIRAMA_TABLE [VIRAMA_COUNT] = '{
    21'h0094D, 21'h009CD, 21'h00A4D, 21'h00ACD, 21'h00B4D, 21'h00BCD, 21'h00C4D,
    21'h00CCD, 21'h00D4D, 21'h00DCA, 21'h01039, 21'h017D2, 21'h01B44, 21'h01BAA,
    21'h01BAB, 21'h0A953, 21'h0AAF6, 21'h1104D, 21'h111C0, 21'h11A3A, 21'h11A99
  };

  typedef enum logic [2:0] {
    JT_OTHER,
    JT_RIGHT,
    JT_LEFT,
    JT_DUAL,
    JT_TRANSPARENT
  } join_type_t;

  // classified word handed from front to back
  typedef struct packed {
    join_type_t jt;
    logic       virama;
    logic       is_zwnj;
    logic       is_zwj;
    logic       last;
  } cls_t;

  localparam int unsigned CLS_W = $bits(cls_t);

endpackage

// ===== sv/joiner_context_checker_top.sv =====
// Channel   Ports                                  Handshake
// input     in_code_point[20:0], in_last_of_label  in_push, in_full
// result    out_label_valid                        out_pop, out_empty
//
// One code point per cycle while in_full is low; the front classifies a word
// as it is pushed into a QUEUE_DEPTH-entry queue and the back applies the
// rules at one word per cycle while the result queue has room. Synchronous
// active-low reset empties both queues and clears the label context. in_full
// rises only after the back has stalled behind a full two-entry result queue
// long enough to fill the input queue.
module joiner_context_checker_top import jcc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [CP_W-1:0] in_code_point,
  input  logic            in_last_of_label,
  output logic            out_empty,
  input  logic            out_pop,
  output logic            out_label_valid
);

  cls_t             front_cls;
  cls_t             back_cls;
  logic [CLS_W-1:0] q_rd_data;
  logic             q_empty;
  logic             q_pop;
  logic             res_full;
  logic             res_push;
  logic             res_valid;

  jcc_front u_front (
    .code_point    (in_code_point),
    .last_of_label (in_last_of_label),
    .cls           (front_cls)
  );

  jcc_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_cls),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .full    (in_full)
  );

  assign back_cls = cls_t'(q_rd_data);

  jcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (back_cls),
    .cls_empty (q_empty),
    .cls_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_valid (res_valid)
  );

  jcc_fifo #(
    .WIDTH (1),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_valid),
    .pop     (out_pop),
    .rd_data (out_label_valid),
    .empty   (out_empty),
    .full    (res_full)
  );

endmodule

// ===== sv/jcc_fifo.sv =====
module jcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fifo count above depth");

  a_pop_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !push) |=> empty)
    else $error("fifo left empty without a push");

  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full && $stable(wr_ptr_r))
    else $error("fifo accepted a word while full");

endmodule

// ===== sv/jcc_front.sv =====
module jcc_front import jcc_pkg::*; (
  input  logic [CP_W-1:0] code_point,
  input  logic            last_of_label,
  output cls_t            cls
);

  logic virama_hit;

  always_comb begin
    virama_hit = 1'b0;
    for (int i = 0; i < VIRAMA_COUNT; i++) begin
      if (VIRAMA_TABLE[i] == code_point) begin
        virama_hit = 1'b1;
      end
    end
  end

  always_comb begin
    cls.virama    = virama_hit;
    cls.is_zwnj   = (code_point == CP_ZWNJ);
    cls.is_zwj    = (code_point == CP_ZWJ);
    cls.last      = last_of_label;
    if (code_point == CP_ZWNJ || code_point == CP_ZWJ ||
        code_point == CP_FATHATAN || code_point == CP_ALM) begin
      cls.jt = JT_TRANSPARENT;
    end else if (code_point == CP_BEH || code_point == CP_LAM) begin
      cls.jt = JT_DUAL;
    end else if (code_point == CP_ALEF) begin
      cls.jt = JT_RIGHT;
    end else begin
      cls.jt = JT_OTHER;
    end
  end

endmodule

// ===== sv/jcc_back.sv =====
module jcc_back import jcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cls_t cls,
  input  logic cls_empty,
  output logic cls_pop,
  input  logic res_full,
  output logic res_push,
  output logic res_valid
);

  logic prev_virama_r, prev_virama_nxt;
  logic prev_ld_r, prev_ld_nxt;
  logic pend_r, pend_nxt;
  logic fail_r, fail_nxt;
  logic pend_mid;
  logic fail_mid;

  assign cls_pop  = !cls_empty && !res_full;
  assign res_push = cls_pop && cls.last;

  always_comb begin
    pend_mid = pend_r;
    fail_mid = fail_r;
    // settle a waiting ZWNJ on the next non-transparent character
    if (pend_r && cls.jt != JT_TRANSPARENT) begin
      if (cls.jt != JT_RIGHT && cls.jt != JT_DUAL) begin
        fail_mid = 1'b1;
      end
      pend_mid = 1'b0;
    end
    if (cls.is_zwnj && !prev_virama_r) begin
      if (prev_ld_r) begin
        pend_mid = 1'b1;
      end else begin
        fail_mid = 1'b1;
      end
    end
    if (cls.is_zwj && !prev_virama_r) begin
      fail_mid = 1'b1;
    end
    res_valid = !fail_mid && !pend_mid;

    prev_virama_nxt = prev_virama_r;
    prev_ld_nxt     = prev_ld_r;
    pend_nxt        = pend_r;
    fail_nxt        = fail_r;
    if (cls_pop) begin
      if (cls.last) begin
        // label done: drop all context
        prev_virama_nxt = 1'b0;
        prev_ld_nxt     = 1'b0;
        pend_nxt        = 1'b0;
        fail_nxt        = 1'b0;
      end else begin
        prev_virama_nxt = cls.virama;
        if (cls.jt != JT_TRANSPARENT) begin
          prev_ld_nxt = (cls.jt == JT_LEFT) || (cls.jt == JT_DUAL);
        end
        pend_nxt = pend_mid;
        fail_nxt = fail_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_virama_r <= 1'b0;
      prev_ld_r     <= 1'b0;
      pend_r        <= 1'b0;
      fail_r        <= 1'b0;
    end else begin
      prev_virama_r <= prev_virama_nxt;
      prev_ld_r     <= prev_ld_nxt;
      pend_r        <= pend_nxt;
      fail_r        <= fail_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_pop && cls.last) |=> (!prev_virama_r && !prev_ld_r && !pend_r && !fail_r))
    else $error("context not cleared after end of label");

  a_zwj_needs_virama: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_pop && cls.is_zwj && !prev_virama_r && !cls.last) |=> fail_r)
    else $error("ZWJ without virama not flagged");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_r && !(cls_pop && cls.last)) |=> fail_r)
    else $error("failure dropped inside a label");

  a_pending_blocks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && pend_r && cls.jt == JT_TRANSPARENT) |-> !res_valid)
    else $error("label passed with ZWNJ still pending");

endmodule
